// File: sv/edge_avoid_drive_sequencer_top_assert.svh
// Assertion macros for the edge avoiding drive sequencer.
// Used by the top level only; expands to nothing when SYNTHESIS is defined.
`ifndef EDGE_AVOID_DRIVE_SEQUENCER_TOP_ASSERT_SVH
`define EDGE_AVOID_DRIVE_SEQUENCER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define EADS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define EADS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define EADS_ASSERT_IMP(label, ante, cons, msg)
`define EADS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: sv/eads_pkg.sv
// Package for the edge avoiding drive sequencer: types, constants and helpers.
// Used by eads_step and edge_avoid_drive_sequencer_top; depends on nothing.
package eads_pkg;

   localparam int TIME_WIDTH = 32;

   typedef logic [TIME_WIDTH-1:0] time_type;

   typedef enum logic [1:0] {
      MODE_FORWARD = 2'd0,
      MODE_TURN    = 2'd1,
      MODE_BACKUP  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      CSR_PWM_PERIOD  = 3'd0,
      CSR_DRIVE_SPEED = 3'd1,
      CSR_TICK_DIVIDE = 3'd2,
      CSR_BACKUP      = 3'd3,
      CSR_TURN_BASE   = 3'd4
   } csr_index_type;

   localparam logic [7:0] PWM_PERIOD_RESET  = 8'd20;
   localparam logic [7:0] DRIVE_SPEED_RESET = 8'd20;
   localparam logic [7:0] TICK_DIVIDE_RESET = 8'd3;
   localparam logic [7:0] BACKUP_RESET      = 8'd2;
   localparam logic [7:0] TURN_BASE_RESET   = 8'd10;

   localparam logic [36:0] LCG_MUL = 37'd17;
   localparam logic [36:0] LCG_ADD = 37'd13;

   localparam logic [3:0] PAT_FORWARD = 4'h9;
   localparam logic [3:0] PAT_REVERSE = 4'h6;
   localparam logic [3:0] PAT_LEFT    = 4'hA;
   localparam logic [7:0] KEEP_MASK   = 8'hF0;
   localparam logic [7:0] BUZZER_OFF  = 8'h10;

   localparam logic [0:0] OP_TICK = 1'b0;

   typedef struct packed {
      logic [7:0] pwm_period;
      logic [7:0] drive_speed;
      logic [7:0] tick_divide;
      logic [7:0] backup_ticks;
      logic [7:0] turn_base_ticks;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  tick_prescale;
      time_type    time_count;
      time_type    backup_deadline;
      time_type    turn_deadline;
      logic [31:0] lcg_value;
      logic [1:0]  lcg_mod3;
      logic [7:0]  pwm_counter;
   } state_type;

   // Residue modulo three of a six-bit value by folding base-four digits.
   function automatic logic [1:0] mod3_fold(input logic [5:0] v);
      logic [3:0] s;
      logic [2:0] t;
      logic [2:0] u;
      s = {2'b00, v[1:0]} + {2'b00, v[3:2]} + {2'b00, v[5:4]};
      t = {1'b0, s[1:0]} + {1'b0, s[3:2]};
      u = {1'b0, t[1:0]} + {2'b00, t[2]};
      if (u >= 3'd3) begin
         u = u - 3'd3;
      end
      return u[1:0];
   endfunction

   // Residue modulo six from the residues modulo two and modulo three.
   function automatic logic [2:0] mod6_join(input logic b, input logic [1:0] r);
      logic [2:0] m;
      case ({b, r})
         3'b000:  m = 3'd0;
         3'b101:  m = 3'd1;
         3'b010:  m = 3'd2;
         3'b100:  m = 3'd3;
         3'b001:  m = 3'd4;
         3'b110:  m = 3'd5;
         default: m = 3'd0;
      endcase
      return m;
   endfunction

endpackage

// File: sv/eads_step.sv
// Next-state and result logic for one item of the edge avoiding drive sequencer.
// Depends on eads_pkg.
module eads_step (
   input  eads_pkg::state_type state_cur,
   input  eads_pkg::cfg_type   cfg,
   input  logic                operation,
   input  logic [7:0]          raw_pins,
   output eads_pkg::state_type state_next,
   output logic [7:0]          port_byte,
   output eads_pkg::mode_type  mode
);

   logic [36:0] lcg_sum1;
   logic [36:0] lcg_sum2;
   logic [31:0] lcg_x1;
   logic [31:0] lcg_x2;
   logic [1:0]  lcg_r1;
   logic [1:0]  lcg_r2;
   logic [2:0]  draw;
   logic [7:0]  prescale_inc;
   logic [7:0]  pwm_load;
   logic [7:0]  keep;
   logic [3:0]  pattern;

   // The generator state carries its residue modulo three, updated from the
   // carry out of each advance since two to the 32nd is one modulo three.
   always_comb begin
      lcg_sum1 = {5'd0, state_cur.lcg_value} * eads_pkg::LCG_MUL + eads_pkg::LCG_ADD;
      lcg_x1   = lcg_sum1[31:0];
      lcg_r1   = eads_pkg::mod3_fold(6'({2'b00, state_cur.lcg_mod3, 1'b0} + 6'd1) +
                 {3'd0, eads_pkg::mod3_fold({1'b0, lcg_sum1[36:32]}), 1'b0});
      lcg_sum2 = {5'd0, lcg_x1} * eads_pkg::LCG_MUL + eads_pkg::LCG_ADD;
      lcg_x2   = lcg_sum2[31:0];
      lcg_r2   = eads_pkg::mod3_fold(6'({3'b000, lcg_r1, 1'b0} + 6'd1) +
                 {3'd0, eads_pkg::mod3_fold({1'b0, lcg_sum2[36:32]}), 1'b0});
      draw     = eads_pkg::mod6_join(lcg_x1[0], lcg_r1);
   end

   always_comb begin
      state_next   = state_cur;
      prescale_inc = state_cur.tick_prescale + 8'd1;
      mode         = eads_pkg::MODE_FORWARD;
      keep         = eads_pkg::BUZZER_OFF | 8'h20;
      pattern      = eads_pkg::PAT_FORWARD;
      pwm_load     = (state_cur.pwm_counter == 8'd0) ? cfg.pwm_period : state_cur.pwm_counter;
      if (operation == eads_pkg::OP_TICK) begin
         if (prescale_inc >= cfg.tick_divide) begin
            state_next.tick_prescale = 8'd0;
            state_next.time_count    = state_cur.time_count + eads_pkg::time_type'(1);
         end else begin
            state_next.tick_prescale = prescale_inc;
         end
      end else begin
         if (state_cur.backup_deadline > state_cur.time_count) begin
            mode    = eads_pkg::MODE_BACKUP;
            keep    = eads_pkg::BUZZER_OFF | 8'h80;
            pattern = eads_pkg::PAT_REVERSE;
            state_next.turn_deadline = state_cur.time_count +
               eads_pkg::time_type'(cfg.turn_base_ticks) + eads_pkg::time_type'(draw);
            state_next.lcg_value = lcg_x2;
            state_next.lcg_mod3  = lcg_r2;
         end else begin
            if (state_cur.turn_deadline > state_cur.time_count) begin
               mode    = eads_pkg::MODE_TURN;
               keep    = eads_pkg::BUZZER_OFF | 8'h40;
               pattern = eads_pkg::PAT_LEFT;
            end else if (raw_pins[1]) begin
               state_next.backup_deadline = state_cur.time_count +
                  eads_pkg::time_type'(cfg.backup_ticks);
            end
            state_next.lcg_value = lcg_x1;
            state_next.lcg_mod3  = lcg_r1;
         end
         state_next.pwm_counter = pwm_load - 8'd1;
      end
      if (pwm_load < cfg.drive_speed) begin
         port_byte = (keep & eads_pkg::KEEP_MASK) | {4'h0, pattern};
      end else begin
         port_byte = keep & eads_pkg::KEEP_MASK;
      end
   end

endmodule

// File: sv/edge_avoid_drive_sequencer_top.sv
// Top level of the edge avoiding drive sequencer: handshakes, registers, state.
// Depends on eads_pkg, eads_step and edge_avoid_drive_sequencer_top_assert.svh.
//
// The block takes one item per clock cycle, ticks and control steps alike. An
// accepted item sits in the input register while the single-pass step logic
// works on it; a control step's result is then held in the result register
// and appears on the rsp_ port, while a tick only moves the timer and gives
// no result. The input side stalls only when a control step waits behind a
// result that has not been taken. The configuration port is always ready; the
// user writes it only while the block is idle; the block does not enforce this.
`include "edge_avoid_drive_sequencer_top_assert.svh"

module edge_avoid_drive_sequencer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_operation,
   input  logic [7:0] req_raw_pins,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_port_byte,
   output logic [1:0] rsp_mode,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data
);

   eads_pkg::cfg_type   cfg_ff;
   eads_pkg::state_type state_ff;
   eads_pkg::state_type state_in;
   eads_pkg::mode_type  mode_in;
   logic                in_valid_ff;
   logic                in_op_ff;
   logic [7:0]          in_pins_ff;
   logic                rsp_valid_ff;
   logic [7:0]          rsp_port_ff;
   logic [7:0]          port_in;
   eads_pkg::mode_type  rsp_mode_ff;
   logic                out_free;
   logic                advance;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && ((in_op_ff == eads_pkg::OP_TICK) || out_free);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_port_byte = rsp_port_ff;
   assign rsp_mode      = rsp_mode_ff;

   eads_step u_step (
      .state_cur (state_ff),
      .cfg       (cfg_ff),
      .operation (in_op_ff),
      .raw_pins  (in_pins_ff),
      .state_next(state_in),
      .port_byte (port_in),
      .mode      (mode_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pwm_period      <= eads_pkg::PWM_PERIOD_RESET;
         cfg_ff.drive_speed     <= eads_pkg::DRIVE_SPEED_RESET;
         cfg_ff.tick_divide     <= eads_pkg::TICK_DIVIDE_RESET;
         cfg_ff.backup_ticks    <= eads_pkg::BACKUP_RESET;
         cfg_ff.turn_base_ticks <= eads_pkg::TURN_BASE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            eads_pkg::CSR_PWM_PERIOD:  cfg_ff.pwm_period      <= csr_data;
            eads_pkg::CSR_DRIVE_SPEED: cfg_ff.drive_speed     <= csr_data;
            eads_pkg::CSR_TICK_DIVIDE: cfg_ff.tick_divide     <= csr_data;
            eads_pkg::CSR_BACKUP:      cfg_ff.backup_ticks    <= csr_data;
            eads_pkg::CSR_TURN_BASE:   cfg_ff.turn_base_ticks <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff   <= req_operation;
         in_pins_ff <= req_raw_pins;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && (in_op_ff != eads_pkg::OP_TICK)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && (in_op_ff != eads_pkg::OP_TICK)) begin
         rsp_port_ff <= port_in;
         rsp_mode_ff <= mode_in;
      end
   end

   `EADS_ASSERT_IMP(a_port_marks, rsp_valid_ff, $onehot(rsp_port_ff[7:5]) && rsp_port_ff[4] && ((rsp_mode_ff == eads_pkg::MODE_BACKUP) == rsp_port_ff[7]) && ((rsp_mode_ff == eads_pkg::MODE_TURN) == rsp_port_ff[6]), "port byte mode bits disagree with mode")
   `EADS_ASSERT_NEXT(a_tick_silent, advance && (in_op_ff == eads_pkg::OP_TICK) && !rsp_valid_ff, !rsp_valid_ff, "tick produced a result")
   `EADS_ASSERT_IMP(a_time_step, !$past(reset) && (state_ff.time_count != $past(state_ff.time_count)), state_ff.time_count == $past(state_ff.time_count) + eads_pkg::time_type'(1), "time counter jumped")

endmodule
